// File: rtl/voxel_activity_position_sampler_macros.svh
// assertion macros for the voxel sampler checker
`ifndef VOXEL_ACTIVITY_POSITION_SAMPLER_MACROS_SVH
`define VOXEL_ACTIVITY_POSITION_SAMPLER_MACROS_SVH
// implication checked on every clock edge outside reset
`define VAPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define VAPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/vaps_pkg.sv
// ---------------------------------------------------------------------------
// vaps_pkg
// shared constants and types of the voxel activity position sampler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package vaps_pkg;
	localparam int MAX_VOXELS = 65536;
	localparam int AW = $clog2(MAX_VOXELS);
	localparam int CW = AW + 1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [2:0] REG_COUNT_X = 3'd0;
	localparam logic [2:0] REG_COUNT_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd4;
	localparam logic [2:0] REG_PITCH_X = 3'd5;
	localparam logic [2:0] REG_PITCH_Y = 3'd6;
	localparam logic [2:0] REG_PITCH_Z = 3'd7;

	// one classified sample job passed from front to back
	typedef struct packed {
		logic [31:0] u_select;
		logic [15:0] u_x;
		logic [15:0] u_y;
		logic [15:0] u_z;
		logic [31:0] total;
		logic [CW-1:0] count;
	} job_t;
endpackage

// File: rtl/vaps_ram.sv
// ---------------------------------------------------------------------------
// vaps_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vaps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/vaps_back.sv
// ---------------------------------------------------------------------------
// vaps_back
// sample engine: binary search, index split by division, axis positions
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vaps_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input vaps_pkg::job_t job,
	output logic job_take,
	output logic [vaps_pkg::AW-1:0] raddr,
	input logic [31:0] rdata,
	input logic [16:0] count_x,
	input logic [16:0] count_y,
	input logic [23:0] origin_x,
	input logic [23:0] origin_y,
	input logic [23:0] origin_z,
	input logic [15:0] pitch_x,
	input logic [15:0] pitch_y,
	input logic [15:0] pitch_z,
	output logic res_valid,
	output logic [31:0] res_x,
	output logic [31:0] res_y,
	output logic [31:0] res_z,
	output logic [15:0] res_index
);
	localparam int AW = vaps_pkg::AW;
	localparam int CW = vaps_pkg::CW;
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_WAIT = 4'd3;
	localparam logic [3:0] S_CMP = 4'd4;
	localparam logic [3:0] S_DIV1 = 4'd5;
	localparam logic [3:0] S_DIV2 = 4'd6;
	localparam logic [3:0] S_AXIS = 4'd7;
	localparam logic [3:0] S_SUM = 4'd8;

	logic [3:0] state_q;
	vaps_pkg::job_t job_q;
	logic [63:0] target_q;
	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic [CW-1:0] quo_q, rem_q, div_q;
	logic [4:0] bit_q;
	logic [CW-1:0] nx_q, ny_q, nz_q;
	logic [1:0] axis_q;
	logic [47:0] pn_q, pu_q;
	logic [31:0] px_q, py_q;
	logic [15:0] pit;
	logic [23:0] org;
	logic [15:0] uax;
	logic [CW-1:0] nax;
	logic [16:0] cx, cy;
	logic [CW-1:0] rem_sh;
	logic signed [49:0] sum;
	logic [31:0] sat;

	assign cx = (count_x == '0) ? 17'd1 : count_x;
	assign cy = (count_y == '0) ? 17'd1 : count_y;
	assign job_take = (state_q == S_IDLE) && job_valid;
	assign raddr = mid_q[AW-1:0];
	assign rem_sh = {rem_q[CW-2:0], quo_q[CW-1]};

	// per-axis operand selection
	always_comb begin
		case (axis_q)
			2'd0: begin pit = pitch_x; org = origin_x; uax = job_q.u_x; nax = nx_q; end
			2'd1: begin pit = pitch_y; org = origin_y; uax = job_q.u_y; nax = ny_q; end
			default: begin pit = pitch_z; org = origin_z; uax = job_q.u_z; nax = nz_q; end
		endcase
	end

	// position sum and saturation
	always_comb begin
		sum = 50'(signed'(org)) + signed'({2'b00, pn_q})
			+ signed'({2'b00, 15'd0, pu_q[47:15]}) - signed'({34'd0, pit});
		if (sum > 50'sd2147483647) sat = 32'h7fffffff;
		else if (sum < -50'sd2147483648) sat = 32'h80000000;
		else sat = sum[31:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					state_q <= S_MUL;
				end
				S_MUL: begin
					target_q <= job_q.u_select * job_q.total;
					lo_q <= '0;
					hi_q <= job_q.count - CW'(1);
					state_q <= S_RD;
				end
				S_RD: if (lo_q < hi_q) begin
					mid_q <= lo_q + ((hi_q - lo_q) >> 1);
					state_q <= S_WAIT;
				end else begin
					// divide index by count_x
					quo_q <= lo_q;
					rem_q <= '0;
					div_q <= CW'(cx);
					bit_q <= 5'(CW);
					state_q <= S_DIV1;
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					if ({rdata, 32'd0} > target_q) hi_q <= mid_q;
					else lo_q <= mid_q + CW'(1);
					state_q <= S_RD;
				end
				S_DIV1, S_DIV2: begin
					if (rem_sh >= div_q) begin
						rem_q <= rem_sh - div_q;
						quo_q <= {quo_q[CW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[CW-2:0], 1'b0};
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						quo_q <= quo_q;
						rem_q <= rem_q;
						if (state_q == S_DIV1) begin
							nx_q <= rem_q;
							quo_q <= quo_q;
							rem_q <= '0;
							div_q <= CW'(cy);
							bit_q <= 5'(CW);
							state_q <= S_DIV2;
						end else begin
							ny_q <= rem_q;
							nz_q <= quo_q;
							axis_q <= 2'd0;
							state_q <= S_AXIS;
						end
					end
				end
				S_AXIS: begin
					pn_q <= pit * 32'(nax);
					pu_q <= 48'(32'(pit) * 32'(uax));
					state_q <= S_SUM;
				end
				S_SUM: begin
					case (axis_q)
						2'd0: px_q <= sat;
						2'd1: py_q <= sat;
						default: ;
					endcase
					if (axis_q == 2'd2) begin
						res_valid <= 1'b1;
						res_x <= px_q;
						res_y <= py_q;
						res_z <= sat;
						res_index <= lo_q[15:0];
						state_q <= S_IDLE;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= S_AXIS;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/vaps_front.sv
// ---------------------------------------------------------------------------
// vaps_front
// accepts beats, runs loads, answers rejects, queues samples for the back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vaps_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic func,
	input logic [15:0] activity,
	input logic last,
	input logic [31:0] u_select,
	input logic [15:0] u_x,
	input logic [15:0] u_y,
	input logic [15:0] u_z,
	output logic we,
	output logic [vaps_pkg::AW-1:0] waddr,
	output logic [31:0] wdata,
	output logic job_valid,
	output vaps_pkg::job_t job,
	input logic job_take,
	input logic back_done,
	output logic res_valid,
	output logic [15:0] res_index,
	output logic [1:0] res_status
);
	localparam int CW = vaps_pkg::CW;
	logic [CW-1:0] count_q;
	logic [31:0] total_q;
	logic ready_q;
	logic pending_q;
	logic acc;
	logic [CW-1:0] cnt;
	logic [31:0] tot;
	logic [32:0] sum;

	// one sample in flight at a time
	assign busy = pending_q;
	assign acc = start && !busy;
	assign cnt = ready_q ? '0 : count_q;
	assign tot = ready_q ? '0 : total_q;
	assign sum = {1'b0, tot} + 33'(activity);
	assign we = acc && (func == vaps_pkg::FUNC_LOAD)
		&& (cnt < CW'(vaps_pkg::MAX_VOXELS)) && !sum[32];
	assign waddr = cnt[vaps_pkg::AW-1:0];
	assign wdata = sum[31:0];

	// load bookkeeping, sample queue and immediate results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			ready_q <= 1'b0;
			pending_q <= 1'b0;
			job_valid <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (job_take) job_valid <= 1'b0;
			if (back_done) pending_q <= 1'b0;
			if (acc) begin
				res_index <= 16'(cnt);
				if (func == vaps_pkg::FUNC_LOAD) begin
					res_valid <= 1'b1;
					res_status <= we ? vaps_pkg::ST_OK : vaps_pkg::ST_FULL;
					count_q <= we ? cnt + CW'(1) : cnt;
					total_q <= we ? sum[31:0] : tot;
					ready_q <= last;
				end else if (!ready_q || total_q == '0 || count_q == '0) begin
					res_valid <= 1'b1;
					res_status <= vaps_pkg::ST_EMPTY;
					res_index <= '0;
				end else begin
					pending_q <= 1'b1;
					job_valid <= 1'b1;
					job <= '{u_select: u_select, u_x: u_x, u_y: u_y, u_z: u_z,
						total: total_q, count: count_q};
				end
			end
		end
	end
endmodule

// File: rtl/voxel_activity_position_sampler.sv
// ---------------------------------------------------------------------------
// voxel_activity_position_sampler
// inverse cdf sampling of a voxel position from loaded activities
// ---------------------------------------------------------------------------
// Usage: drive func and payload with start while busy is low; a beat is
// taken at that edge. func 0 appends one activity to the cumulative table
// (last closes it); func 1 draws a sample from a closed table.
// Every beat gives exactly one result, marked by done for one cycle; the
// receiver cannot stall, so results are never held.
// A load or a rejected sample answers the next cycle and the
// block can take a beat every cycle. A sample runs a binary search over the
// table (each step passes S_RD, S_WAIT and S_CMP around the registered ram
// read, up to 16 steps), two bit-serial divisions for the index split, and
// S_AXIS then S_SUM per axis; busy is high from the accepting edge until
// done and drops the cycle after done.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// Reset clears the table count, total and closed flag; the ram holds no
// reset and needs no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module voxel_activity_position_sampler (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data,
	input logic func,
	input logic [15:0] activity,
	input logic last,
	input logic [31:0] u_select,
	input logic [15:0] u_x,
	input logic [15:0] u_y,
	input logic [15:0] u_z,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [15:0] voxel_index,
	output logic [1:0] status
);
	logic [16:0] count_x_q, count_y_q;
	logic [23:0] origin_x_q, origin_y_q, origin_z_q;
	logic [15:0] pitch_x_q, pitch_y_q, pitch_z_q;
	logic we;
	logic [vaps_pkg::AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic job_valid, job_take;
	vaps_pkg::job_t job;
	logic f_valid, b_valid;
	logic [15:0] f_index, b_index;
	logic [1:0] f_status;
	logic [31:0] b_x, b_y, b_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_x_q <= 17'd1;
			count_y_q <= 17'd1;
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			pitch_x_q <= 16'd256;
			pitch_y_q <= 16'd256;
			pitch_z_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				vaps_pkg::REG_COUNT_X: count_x_q <= cfg_data[16:0];
				vaps_pkg::REG_COUNT_Y: count_y_q <= cfg_data[16:0];
				vaps_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				vaps_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				vaps_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
				vaps_pkg::REG_PITCH_X: pitch_x_q <= cfg_data[15:0];
				vaps_pkg::REG_PITCH_Y: pitch_y_q <= cfg_data[15:0];
				vaps_pkg::REG_PITCH_Z: pitch_z_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	vaps_ram #(.WIDTH(32), .DEPTH(vaps_pkg::MAX_VOXELS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	vaps_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .activity(activity), .last(last), .u_select(u_select),
		.u_x(u_x), .u_y(u_y), .u_z(u_z),
		.we(we), .waddr(waddr), .wdata(wdata),
		.job_valid(job_valid), .job(job), .job_take(job_take), .back_done(b_valid),
		.res_valid(f_valid), .res_index(f_index), .res_status(f_status)
	);

	vaps_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .raddr(raddr), .rdata(rdata),
		.count_x(count_x_q), .count_y(count_y_q),
		.origin_x(origin_x_q), .origin_y(origin_y_q), .origin_z(origin_z_q),
		.pitch_x(pitch_x_q), .pitch_y(pitch_y_q), .pitch_z(pitch_z_q),
		.res_valid(b_valid), .res_x(b_x), .res_y(b_y), .res_z(b_z),
		.res_index(b_index)
	);

	// result merge; front and back never finish in the same cycle
	assign done = f_valid || b_valid;
	assign pos_x = b_valid ? b_x : '0;
	assign pos_y = b_valid ? b_y : '0;
	assign pos_z = b_valid ? b_z : '0;
	assign voxel_index = b_valid ? b_index : f_index;
	assign status = b_valid ? vaps_pkg::ST_OK : f_status;
endmodule

// File: rtl/vaps_checker.sv
// ---------------------------------------------------------------------------
// vaps_checker
// port-level checks of the voxel sampler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_activity_position_sampler_macros.svh"
module vaps_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic func,
	input logic [1:0] status,
	input logic [31:0] pos_x
);
	// a load beat answers in the next cycle
	`VAPS_ASSERT_NEXT(a_load_done, clk, arst_n, start && !busy && !func, done, "load without result")
	// status never takes the unused code
	`VAPS_ASSERT_IMP(a_status_code, clk, arst_n, done, status != 2'd3, "bad status code")
	// error results carry a zero position
	`VAPS_ASSERT_IMP(a_err_zero, clk, arst_n, done && status != 2'd0, pos_x == '0, "nonzero pos")
	// busy falls only in the cycle after a result
	`VAPS_ASSERT_IMP(a_busy_fall, clk, arst_n, $fell(busy), $past(done), "busy fell without result")
endmodule

bind voxel_activity_position_sampler vaps_checker u_vaps_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.func(func), .status(status), .pos_x(pos_x)
);
